/* sv/lgdl_pkg.sv */
`default_nettype none

package lgdl_pkg;

  // fixed-point layout
  localparam int TABLE_BITS = 11;
  localparam int FRAC_BITS  = 12;

  localparam int IN_W       = 16;
  localparam int ACC_W      = 48;
  localparam int PROB_W     = 16;
  localparam int LOG_W      = 21;
  localparam int ROM_W      = PROB_W + 2 * LOG_W;
  localparam int ROM_DEPTH  = 1 << TABLE_BITS;
  localparam int IDX_W      = TABLE_BITS;
  localparam int MUL_A_W    = 2 * IN_W;

  // logit to grid index
  localparam int LIM_W      = FRAC_BITS + 5;
  localparam int SCALE_W    = LIM_W + 9;
  localparam int IDX_SHIFT  = FRAC_BITS + 13 - TABLE_BITS;
  localparam logic [SCALE_W-1:0] IDX_ROUND = SCALE_W'(1) << (IDX_SHIFT - 1);
  localparam logic signed [ACC_W-1:0] VAL_MAX = (ACC_W'(1) << (FRAC_BITS + 4)) - ACC_W'(1);
  localparam logic signed [ACC_W-1:0] VAL_MIN = -(ACC_W'(1) << (FRAC_BITS + 4));

  // per-dimension term rounding
  localparam int TERM_SHIFT = 2 * FRAC_BITS;
  localparam int TERM_W     = ACC_W + 1 - TERM_SHIFT;
  localparam logic [ACC_W:0] TERM_ROUND = (ACC_W + 1)'(1) << (TERM_SHIFT - 1);

  // observation codes
  localparam logic [1:0] OBS_ABSENT  = 2'd0;
  localparam logic [1:0] OBS_MISSING = 2'd2;

  // table generation constants, Q.30
  localparam longint ONE30   = 64'sd1 <<< 30;
  localparam longint LN2_Q30 = 64'sd744261118;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_SCALE,
    ST_ACCUM,
    ST_INDEX,
    ST_FETCH,
    ST_RESULT
  } state_e;

  typedef logic [ROM_W-1:0] rom_word_t;
  typedef rom_word_t rom_t [ROM_DEPTH];

  // long division for non-negative operands, elaboration only
  function automatic longint udiv(input longint num, input longint den);
    longint q;
    longint rem;
    int     k;
    q   = 0;
    rem = 0;
    for (k = 62; k >= 0; k--) begin
      rem = (rem <<< 1) | ((num >>> k) & 64'sd1);
      if (rem >= den) begin
        rem = rem - den;
        q   = q | (64'sd1 <<< k);
      end
    end
    return q;
  endfunction

  // exp(-a), a >= 0, Q.30
  function automatic longint exp_neg_q30(input longint a);
    longint n;
    longint r;
    longint term;
    longint sum;
    int     i;
    n    = a / LN2_Q30;
    r    = a - n * LN2_Q30;
    term = ONE30;
    sum  = ONE30;
    for (i = 1; i <= 20; i++) begin
      term = udiv(term * r, longint'(i) * ONE30);
      if ((i & 1) != 0) sum = sum - term;
      else              sum = sum + term;
    end
    if (n >= 62) return 0;
    if (n > 0) sum = (sum + (64'sd1 <<< (n - 1))) >>> n;
    return sum;
  endfunction

  // ln(1+y), y in [0,1], Q.30
  function automatic longint ln1p_q30(input longint y);
    longint z;
    longint z2;
    longint pw;
    longint sum;
    int     i;
    z   = udiv(y * ONE30, 2 * ONE30 + y);
    z2  = (z * z) >>> 30;
    pw  = z;
    sum = 0;
    for (i = 0; i < 16; i++) begin
      sum = sum + udiv(pw, longint'(2 * i + 1));
      pw  = (pw * z2) >>> 30;
    end
    return 2 * sum;
  endfunction

  // table word: probability, -log p, -log(1-p)
  function automatic rom_t build_rom();
    rom_t   rom;
    longint xq;
    longint ax;
    longint e;
    longint l;
    longint den;
    longint num;
    longint p;
    longint lp;
    longint lq;
    int     idx;
    for (idx = 0; idx < ROM_DEPTH; idx++) begin
      xq  = (longint'(idx) - (64'sd1 <<< (TABLE_BITS - 1))) * (64'sd1 <<< (35 - TABLE_BITS));
      ax  = (xq < 0) ? -xq : xq;
      e   = exp_neg_q30(ax);
      l   = ln1p_q30(e);
      den = ONE30 + e;
      num = (xq >= 0) ? ONE30 : e;
      p   = udiv(num * 65536 + (den >>> 1), den);
      if (p > 65535) p = 65535;
      lp  = (((xq < 0) ? -xq : 64'sd0) + l + 8192) >>> 14;
      lq  = (((xq > 0) ? xq : 64'sd0) + l + 8192) >>> 14;
      rom[idx] = {p[PROB_W-1:0], lp[LOG_W-1:0], lq[LOG_W-1:0]};
    end
    return rom;
  endfunction

endpackage

`default_nettype wire

/* sv/logistic_distance_loglik.sv */
// logistic weighted-distance log-likelihood
//
// in channel (in_valid_i / in_ready_o): one word per trait dimension of a species
// pair; offsets are taken on the pair's first word, last_dim_i closes the pair.
// out channel (out_valid_o / out_ready_i): one word per pair with the probability,
// the running saturating log-likelihood total, the counted flag and done_res_o.
// cfg_we_i / cfg_wdata_i write the bias at once, no handshake.
//
// sequence: a non-final dimension goes through accept, square, scale and
// accumulate steps before the next acceptance, set by the one 32x16 multiplier
// being used twice per word. a final dimension adds index, table read and result
// steps before its result shows on out_valid_o, and the next word can be taken in
// the same cycle as that result shows.
// stall: the result sits in an output register; the block keeps working on the
// next pair and only waits in its result step while that register is still full.
// reset: clears bias, the logit and log-likelihood totals, the output valid, and
// puts the block at the first dimension of a pair.
`default_nettype none

module logistic_distance_loglik
  import lgdl_pkg::*;
(
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    cfg_we_i,
  input  wire logic [IN_W-1:0]         cfg_wdata_i,
  input  wire logic                    in_valid_i,
  output logic                         in_ready_o,
  input  wire logic signed [IN_W-1:0]  trait_a_i,
  input  wire logic signed [IN_W-1:0]  trait_b_i,
  input  wire logic [IN_W-1:0]         weight_i,
  input  wire logic signed [IN_W-1:0]  offset_a_i,
  input  wire logic signed [IN_W-1:0]  offset_b_i,
  input  wire logic [1:0]              observed_i,
  input  wire logic                    last_dim_i,
  input  wire logic                    last_pair_i,
  output logic                         out_valid_o,
  input  wire logic                    out_ready_i,
  output logic [PROB_W-1:0]            probability_o,
  output logic signed [ACC_W-1:0]      total_loglik_o,
  output logic                         counted_o,
  output logic                         done_res_o
);

  // probability and log table, one word per grid point
  localparam rom_t PROB_ROM = build_rom();

  // control and state registers
  state_e                   state_q, state_d;
  logic [IN_W-1:0]          bias_q, bias_d;
  logic signed [ACC_W-1:0]  logit_q, logit_d;
  logic signed [ACC_W-1:0]  loglik_q, loglik_d;
  logic                     first_dim_q, first_dim_d;
  logic                     out_valid_q, out_valid_d;

  // payload registers
  logic [IN_W-1:0]          absd_q, absd_d;
  logic [IN_W-1:0]          weight_q, weight_d;
  logic [1:0]               obs_q, obs_d;
  logic                     last_dim_q, last_dim_d;
  logic                     last_pair_q, last_pair_d;
  logic [ACC_W-1:0]         prod_q, prod_d;
  logic [IDX_W-1:0]         idx_q, idx_d;
  rom_word_t                rom_q;
  logic [PROB_W-1:0]        prob_q, prob_d;
  logic signed [ACC_W-1:0]  total_q, total_d;
  logic                     counted_q, counted_d;
  logic                     done_q, done_d;

  // datapath nets
  logic signed [IN_W:0]     diff;
  logic signed [IN_W+1:0]   base;
  logic [MUL_A_W-1:0]       mul_a;
  logic [IN_W-1:0]          mul_b;
  logic [ACC_W-1:0]         mul_p;
  logic [ACC_W:0]           term_rnd;
  logic [TERM_W-1:0]        term;
  logic signed [ACC_W:0]    logit_sub;
  logic signed [ACC_W-1:0]  logit_sat;
  logic signed [ACC_W-1:0]  val_clamp;
  logic [LIM_W-1:0]         val_u;
  logic [SCALE_W-1:0]       val_scaled;
  logic [IDX_W:0]           idx_full;
  logic [LOG_W-1:0]         log_p;
  logic [LOG_W-1:0]         log_q;
  logic [LOG_W-1:0]         log_sel;
  logic signed [ACC_W:0]    loglik_sub;
  logic signed [ACC_W-1:0]  loglik_sat;
  logic signed [ACC_W-1:0]  loglik_new;
  logic                     counted;
  logic                     out_free;

  // distance of the traits and the pair's starting logit
  assign diff = {trait_a_i[IN_W-1], trait_a_i} - {trait_b_i[IN_W-1], trait_b_i};
  assign base = {{2{bias_q[IN_W-1]}}, bias_q}
              + {{2{offset_a_i[IN_W-1]}}, offset_a_i}
              + {{2{offset_b_i[IN_W-1]}}, offset_b_i};

  // the shared multiplier: |d|*|d| first, then d^2 * weight
  always_comb begin
    if (state_q == ST_SCALE) begin
      mul_a = prod_q[MUL_A_W-1:0];
      mul_b = weight_q;
    end else begin
      mul_a = {{IN_W{1'b0}}, absd_q};
      mul_b = absd_q;
    end
  end
  assign mul_p = ACC_W'(mul_a) * ACC_W'(mul_b);

  // round the term to the logit's scale and subtract, saturating low
  assign term_rnd  = {1'b0, prod_q} + TERM_ROUND;
  assign term      = term_rnd[ACC_W:TERM_SHIFT];
  assign logit_sub = {logit_q[ACC_W-1], logit_q} - {{TERM_SHIFT{1'b0}}, term};
  always_comb begin
    if (logit_sub[ACC_W] != logit_sub[ACC_W-1]) begin
      logit_sat = logit_sub[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end else begin
      logit_sat = logit_sub[ACC_W-1:0];
    end
  end

  // clamp to [-16,16), move to unsigned and round onto the table grid
  always_comb begin
    if (logit_q > VAL_MAX) begin
      val_clamp = VAL_MAX;
    end else if (logit_q < VAL_MIN) begin
      val_clamp = VAL_MIN;
    end else begin
      val_clamp = logit_q;
    end
  end
  assign val_u      = {~val_clamp[LIM_W-1], val_clamp[LIM_W-2:0]};
  assign val_scaled = {1'b0, val_u, 8'b0} + IDX_ROUND;
  assign idx_full   = val_scaled[IDX_SHIFT +: IDX_W + 1];

  // log term for the observation, added to the total with low saturation
  assign log_p      = rom_q[2*LOG_W-1:LOG_W];
  assign log_q      = rom_q[LOG_W-1:0];
  assign counted    = (obs_q != OBS_MISSING);
  assign log_sel    = (obs_q != OBS_ABSENT) ? log_p : log_q;
  assign loglik_sub = {loglik_q[ACC_W-1], loglik_q} - {{(ACC_W+1-LOG_W){1'b0}}, log_sel};
  always_comb begin
    if (loglik_sub[ACC_W] != loglik_sub[ACC_W-1]) begin
      loglik_sat = loglik_sub[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end else begin
      loglik_sat = loglik_sub[ACC_W-1:0];
    end
  end
  assign loglik_new = counted ? loglik_sat : loglik_q;

  assign out_free = !out_valid_q || out_ready_i;

  // sequencer: next state and register updates
  always_comb begin
    state_d     = state_q;
    bias_d      = cfg_we_i ? cfg_wdata_i : bias_q;
    logit_d     = logit_q;
    loglik_d    = loglik_q;
    first_dim_d = first_dim_q;
    out_valid_d = out_valid_q && !out_ready_i;
    absd_d      = absd_q;
    weight_d    = weight_q;
    obs_d       = obs_q;
    last_dim_d  = last_dim_q;
    last_pair_d = last_pair_q;
    prod_d      = prod_q;
    idx_d       = idx_q;
    prob_d      = prob_q;
    total_d     = total_q;
    counted_d   = counted_q;
    done_d      = done_q;
    in_ready_o  = 1'b0;

    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          absd_d      = diff[IN_W] ? IN_W'(-diff) : diff[IN_W-1:0];
          weight_d    = weight_i;
          obs_d       = observed_i;
          last_dim_d  = last_dim_i;
          last_pair_d = last_pair_i;
          if (first_dim_q) begin
            logit_d = {{(ACC_W-IN_W-2){base[IN_W+1]}}, base};
          end
          first_dim_d = 1'b0;
          state_d     = ST_SQUARE;
        end
      end
      ST_SQUARE: begin
        prod_d  = mul_p;
        state_d = ST_SCALE;
      end
      ST_SCALE: begin
        prod_d  = mul_p;
        state_d = ST_ACCUM;
      end
      ST_ACCUM: begin
        logit_d     = logit_sat;
        first_dim_d = last_dim_q;
        state_d     = last_dim_q ? ST_INDEX : ST_IDLE;
      end
      ST_INDEX: begin
        // the top grid point absorbs the rounding carry
        idx_d   = idx_full[IDX_W] ? {IDX_W{1'b1}} : idx_full[IDX_W-1:0];
        state_d = ST_FETCH;
      end
      ST_FETCH: begin
        state_d = ST_RESULT;
      end
      ST_RESULT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          prob_d      = rom_q[ROM_W-1 -: PROB_W];
          total_d     = loglik_new;
          counted_d   = counted;
          done_d      = last_pair_q;
          // end of network restarts the total
          loglik_d    = last_pair_q ? '0 : loglik_new;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      bias_q      <= '0;
      logit_q     <= '0;
      loglik_q    <= '0;
      first_dim_q <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      bias_q      <= bias_d;
      logit_q     <= logit_d;
      loglik_q    <= loglik_d;
      first_dim_q <= first_dim_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    absd_q      <= absd_d;
    weight_q    <= weight_d;
    obs_q       <= obs_d;
    last_dim_q  <= last_dim_d;
    last_pair_q <= last_pair_d;
    prod_q      <= prod_d;
    idx_q       <= idx_d;
    rom_q       <= PROB_ROM[idx_q];
    prob_q      <= prob_d;
    total_q     <= total_d;
    counted_q   <= counted_d;
    done_q      <= done_d;
  end

  assign out_valid_o    = out_valid_q;
  assign probability_o  = prob_q;
  assign total_loglik_o = total_q;
  assign counted_o      = counted_q;
  assign done_res_o     = done_q;

  // a non-final word returns to idle after square, scale and accumulate
  a_short_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && !last_dim_i) |-> ##4 (state_q == ST_IDLE))
    else $error("non-final word did not return to idle in time");

  // a full output register holds the sequencer in its result step
  a_result_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RESULT && out_valid_q && !out_ready_i) |=> (state_q == ST_RESULT))
    else $error("result step left while output register full");

  // a finished result always reaches the output register
  a_result_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RESULT && out_free) |=> out_valid_q)
    else $error("result not loaded");

  // the final pair clears the running total
  a_total_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RESULT && out_free && last_pair_q) |=> (loglik_q == '0))
    else $error("total not cleared after final pair");

  // log-likelihood never goes positive
  a_total_sign: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (total_q[ACC_W-1] || total_q == '0))
    else $error("positive log-likelihood total");

endmodule

`default_nettype wire

/* dv/lgdl_checker.sv */
module lgdl_checker
  import lgdl_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [IN_W-1:0]         cfg_wdata_i,
  input  logic                    in_valid_i,
  input  logic                    in_ready_o,
  input  logic signed [IN_W-1:0]  trait_a_i,
  input  logic signed [IN_W-1:0]  trait_b_i,
  input  logic [IN_W-1:0]         weight_i,
  input  logic signed [IN_W-1:0]  offset_a_i,
  input  logic signed [IN_W-1:0]  offset_b_i,
  input  logic [1:0]              observed_i,
  input  logic                    last_dim_i,
  input  logic                    last_pair_i,
  input  logic                    out_valid_o,
  input  logic                    out_ready_i,
  input  logic [PROB_W-1:0]       probability_o,
  input  logic signed [ACC_W-1:0] total_loglik_o,
  input  logic                    counted_o,
  input  logic                    done_res_o,
  output int                      pending_pairs_o,
  output int                      mismatches_o
);

  timeunit 1ns;
  timeprecision 1ps;

  localparam longint SUM_MAX = (64'sd1 <<< (ACC_W - 1)) - 64'sd1;
  localparam longint SUM_MIN = -(64'sd1 <<< (ACC_W - 1));

  typedef struct packed {
    logic [PROB_W-1:0]       prob;
    logic signed [ACC_W-1:0] total;
    logic                    counted;
    logic                    done;
  } pair_result_t;

  pair_result_t            pair_results_q[$];
  logic signed [IN_W-1:0]  bias_q;
  longint                  logit_sum;
  longint                  loglik_sum;
  logic                    at_first_dim;
  int                      mismatch_cnt;

  function automatic longint clamp48(input longint v);
    if (v > SUM_MAX) return SUM_MAX;
    if (v < SUM_MIN) return SUM_MIN;
    return v;
  endfunction

  // exp(-a) for a >= 0, Q.30, range reduced by ln2
  function automatic longint exp_minus_q30(input longint a);
    longint n;
    longint r;
    longint t;
    longint s;
    int     i;
    n = a / LN2_Q30;
    r = a - n * LN2_Q30;
    t = ONE30;
    s = ONE30;
    for (i = 1; i <= 20; i++) begin
      t = (t * r) / (longint'(i) * ONE30);
      if ((i % 2) != 0) s = s - t;
      else              s = s + t;
    end
    if (n >= 62) return 0;
    if (n > 0) s = (s + (64'sd1 <<< (n - 1))) >>> n;
    return s;
  endfunction

  // ln(1+y) through 2*atanh(y/(2+y)), Q.30
  function automatic longint log_one_plus_q30(input longint y);
    longint z;
    longint z2;
    longint pw;
    longint s;
    int     i;
    z  = (y * ONE30) / (2 * ONE30 + y);
    z2 = (z * z) >>> 30;
    pw = z;
    s  = 0;
    for (i = 0; i < 16; i++) begin
      s  = s + pw / longint'(2 * i + 1);
      pw = (pw * z2) >>> 30;
    end
    return 2 * s;
  endfunction

  task automatic absorb_word();
    longint       diff;
    longint       sq_term;
    longint       lim;
    longint       val;
    longint       idx;
    longint       xq;
    longint       e;
    longint       l;
    longint       den;
    longint       p;
    longint       add;
    pair_result_t res;
    diff    = longint'(trait_a_i) - longint'(trait_b_i);
    sq_term = (longint'(weight_i) * diff * diff + (64'sd1 <<< (2 * FRAC_BITS - 1)))
              >>> (2 * FRAC_BITS);
    if (at_first_dim) begin
      logit_sum = longint'(bias_q) + longint'(offset_a_i) + longint'(offset_b_i);
    end
    logit_sum    = clamp48(logit_sum - sq_term);
    at_first_dim = 1'b0;
    if (last_dim_i) begin
      at_first_dim = 1'b1;
      lim = 64'sd16 <<< FRAC_BITS;
      val = logit_sum;
      if (val < -lim) val = -lim;
      if (val > lim - 1) val = lim - 1;
      idx = ((val + lim) * 256 + (64'sd1 <<< (FRAC_BITS + 12 - TABLE_BITS)))
            >>> (FRAC_BITS + 13 - TABLE_BITS);
      if (idx > (64'sd1 <<< TABLE_BITS) - 1) idx = (64'sd1 <<< TABLE_BITS) - 1;
      xq  = (idx - (64'sd1 <<< (TABLE_BITS - 1))) * (64'sd1 <<< (35 - TABLE_BITS));
      e   = exp_minus_q30((xq < 0) ? -xq : xq);
      l   = log_one_plus_q30(e);
      den = ONE30 + e;
      p   = (((xq >= 0) ? ONE30 : e) * 65536 + den / 2) / den;
      if (p > 65535) p = 65535;
      res.counted = (observed_i != OBS_MISSING);
      if (res.counted) begin
        if (observed_i != OBS_ABSENT) add = -((((xq < 0) ? -xq : 64'sd0) + l + 8192) >>> 14);
        else                          add = -((((xq > 0) ? xq : 64'sd0) + l + 8192) >>> 14);
        loglik_sum = clamp48(loglik_sum + add);
      end
      res.prob  = p[PROB_W-1:0];
      res.total = loglik_sum[ACC_W-1:0];
      res.done  = last_pair_i;
      pair_results_q.push_back(res);
      // end of network clears the running total
      if (last_pair_i) loglik_sum = 0;
    end
  endtask

  task automatic compare_result();
    pair_result_t exp_res;
    if (pair_results_q.size() == 0) begin
      $error("result word with nothing expected");
      mismatch_cnt++;
    end else begin
      exp_res = pair_results_q.pop_front();
      if (probability_o !== exp_res.prob) begin
        $error("probability: expected %0d, got %0d", exp_res.prob, probability_o);
        mismatch_cnt++;
      end
      if (total_loglik_o !== exp_res.total) begin
        $error("total_loglik: expected %0d, got %0d", exp_res.total, total_loglik_o);
        mismatch_cnt++;
      end
      if (counted_o !== exp_res.counted) begin
        $error("counted: expected %0d, got %0d", exp_res.counted, counted_o);
        mismatch_cnt++;
      end
      if (done_res_o !== exp_res.done) begin
        $error("done_res: expected %0d, got %0d", exp_res.done, done_res_o);
        mismatch_cnt++;
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bias_q       = '0;
      logit_sum    = 0;
      loglik_sum   = 0;
      at_first_dim = 1'b1;
      mismatch_cnt = 0;
      pair_results_q.delete();
      pending_pairs_o <= 0;
      mismatches_o    <= 0;
    end else begin
      if (cfg_we_i) bias_q = cfg_wdata_i;
      if (in_valid_i && in_ready_o) absorb_word();
      if (out_valid_o && out_ready_i) compare_result();
      pending_pairs_o <= pair_results_q.size();
      mismatches_o    <= mismatch_cnt;
    end
  end

endmodule

/* dv/testbench.sv */
module testbench;

  timeunit 1ns;
  timeprecision 1ps;

  import lgdl_pkg::*;

  // observation codes not named in the package
  localparam logic [1:0] OBS_PRESENT = 2'd1;
  localparam logic [1:0] OBS_ODD     = 2'd3;

  // random part, split over the bias settings
  localparam int WORDS_PER_PHASE = 123;
  localparam int NUM_PHASES      = 6;

  typedef struct {
    logic signed [IN_W-1:0] ta;
    logic signed [IN_W-1:0] tb;
    logic [IN_W-1:0]        w;
    logic signed [IN_W-1:0] oa;
    logic signed [IN_W-1:0] ob;
    logic [1:0]             obs;
    logic                   ld;
    logic                   lp;
  } dim_word_t;

  logic                    clk_i = 1'b0;
  logic                    rst_ni;
  logic                    cfg_we_i;
  logic [IN_W-1:0]         cfg_wdata_i;
  logic                    in_valid_i;
  logic                    in_ready_o;
  logic signed [IN_W-1:0]  trait_a_i;
  logic signed [IN_W-1:0]  trait_b_i;
  logic [IN_W-1:0]         weight_i;
  logic signed [IN_W-1:0]  offset_a_i;
  logic signed [IN_W-1:0]  offset_b_i;
  logic [1:0]              observed_i;
  logic                    last_dim_i;
  logic                    last_pair_i;
  logic                    out_valid_o;
  logic                    out_ready_i;
  logic [PROB_W-1:0]       probability_o;
  logic signed [ACC_W-1:0] total_loglik_o;
  logic                    counted_o;
  logic                    done_res_o;

  int   pending_pairs;
  int   mismatches;
  // no idling on either side while set
  logic calm;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  logistic_distance_loglik i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .trait_a_i     (trait_a_i),
    .trait_b_i     (trait_b_i),
    .weight_i      (weight_i),
    .offset_a_i    (offset_a_i),
    .offset_b_i    (offset_b_i),
    .observed_i    (observed_i),
    .last_dim_i    (last_dim_i),
    .last_pair_i   (last_pair_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .probability_o (probability_o),
    .total_loglik_o(total_loglik_o),
    .counted_o     (counted_o),
    .done_res_o    (done_res_o)
  );

  lgdl_checker i_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .trait_a_i      (trait_a_i),
    .trait_b_i      (trait_b_i),
    .weight_i       (weight_i),
    .offset_a_i     (offset_a_i),
    .offset_b_i     (offset_b_i),
    .observed_i     (observed_i),
    .last_dim_i     (last_dim_i),
    .last_pair_i    (last_pair_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .probability_o  (probability_o),
    .total_loglik_o (total_loglik_o),
    .counted_o      (counted_o),
    .done_res_o     (done_res_o),
    .pending_pairs_o(pending_pairs),
    .mismatches_o   (mismatches)
  );

  function automatic dim_word_t make_dim(input logic [IN_W-1:0] ta, input logic [IN_W-1:0] tb,
                                         input logic [IN_W-1:0] w, input logic [IN_W-1:0] oa,
                                         input logic [IN_W-1:0] ob, input logic [1:0] obs,
                                         input logic ld, input logic lp);
    dim_word_t dw;
    dw.ta  = ta;
    dw.tb  = tb;
    dw.w   = w;
    dw.oa  = oa;
    dw.ob  = ob;
    dw.obs = obs;
    dw.ld  = ld;
    dw.lp  = lp;
    return dw;
  endfunction

  // signed value whose magnitude is spread over powers of two up to 2^max_log
  function automatic logic [IN_W-1:0] narrow_signed(input int max_log);
    int mag;
    mag = $urandom_range(0, 1 << $urandom_range(0, max_log));
    if ($urandom_range(0, 1) == 1) mag = -mag;
    return IN_W'(mag);
  endfunction

  // one trait dimension with random content; most words keep the logit near the
  // table range, a fifth are raw noise across every bit
  function automatic dim_word_t random_dim(input logic ld);
    dim_word_t dw;
    int        wl;
    dw.ta = IN_W'($urandom);
    if ($urandom_range(0, 4) == 0) begin
      dw.tb = IN_W'($urandom);
      dw.w  = IN_W'($urandom);
      dw.oa = IN_W'($urandom);
      dw.ob = IN_W'($urandom);
    end else begin
      dw.tb = dw.ta - narrow_signed(12);
      wl    = $urandom_range(0, 16);
      dw.w  = (wl == 16) ? IN_W'($urandom) : IN_W'($urandom_range(0, 1 << wl));
      dw.oa = narrow_signed(14);
      dw.ob = narrow_signed(14);
    end
    dw.obs = 2'($urandom_range(0, 3));
    dw.ld  = ld;
    // stray last_pair on inner dimensions is noise the block must ignore
    dw.lp  = ld ? ($urandom_range(0, 7) == 0) : ($urandom_range(0, 5) == 0);
    return dw;
  endfunction

  // present one word after a random gap and hold it until taken
  task automatic send_dim(input dim_word_t dw);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    trait_a_i   <= dw.ta;
    trait_b_i   <= dw.tb;
    weight_i    <= dw.w;
    offset_a_i  <= dw.oa;
    offset_b_i  <= dw.ob;
    observed_i  <= dw.obs;
    last_dim_i  <= dw.ld;
    last_pair_i <= dw.lp;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  // hold off until every pair result is back, then let the pipe settle
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_pairs != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
  endtask

  task automatic write_bias(input logic [IN_W-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // result side: random ready gaps per word, none while calm
  initial begin : result_sink
    int gap;
    out_ready_i = 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      gap = calm ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
    end
  end

  initial begin : stimulus
    dim_word_t        dw;
    logic [IN_W-1:0]  phase_bias [NUM_PHASES];
    int               phase;
    int               sent;
    int               ndim;
    int               k;

    rst_ni      = 1'b0;
    calm        = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = '0;
    in_valid_i  = 1'b0;
    trait_a_i   = '0;
    trait_b_i   = '0;
    weight_i    = '0;
    offset_a_i  = '0;
    offset_b_i  = '0;
    observed_i  = OBS_ABSENT;
    last_dim_i  = 1'b0;
    last_pair_i = 1'b0;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed words at zero bias
    write_bias(16'h0000);
    // logit zero under each observation code, missing one leaves the total alone
    send_dim(make_dim(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, OBS_ABSENT,
                      1'b1, 1'b0));
    send_dim(make_dim(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, OBS_PRESENT,
                      1'b1, 1'b0));
    send_dim(make_dim(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, OBS_MISSING,
                      1'b1, 1'b0));
    send_dim(make_dim(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, OBS_ODD,
                      1'b1, 1'b0));
    // logit above the table, clamped to the top entry
    send_dim(make_dim(16'h0000, 16'h0000, 16'h0000, 16'h7fff, 16'h7fff, OBS_PRESENT,
                      1'b1, 1'b0));
    send_dim(make_dim(16'h0000, 16'h0000, 16'h0000, 16'h7fff, 16'h7fff, OBS_ABSENT,
                      1'b1, 1'b0));
    // logit at the table's lower bound, on the bottom entry
    send_dim(make_dim(16'h0000, 16'h0000, 16'h0000, 16'h8000, 16'h8000, OBS_ABSENT,
                      1'b1, 1'b0));
    send_dim(make_dim(16'h0000, 16'h0000, 16'h0000, 16'h8000, 16'h8000, OBS_PRESENT,
                      1'b1, 1'b0));
    // widest trait gap at full weight
    send_dim(make_dim(16'h7fff, 16'h8000, 16'hffff, 16'h7fff, 16'h7fff, OBS_PRESENT,
                      1'b1, 1'b0));
    // three-dimension pair: later offsets ignored, stray last_pair inside
    send_dim(make_dim(16'h0100, 16'h00c0, 16'h1000, 16'h1000, 16'h0800, OBS_ABSENT,
                      1'b0, 1'b0));
    send_dim(make_dim(16'hff00, 16'hff40, 16'h2000, 16'h7fff, 16'h8000, OBS_MISSING,
                      1'b0, 1'b1));
    send_dim(make_dim(16'h0020, 16'h0000, 16'hffff, 16'h8000, 16'h7fff, OBS_PRESENT,
                      1'b1, 1'b0));
    // end of network, then a fresh total
    send_dim(make_dim(16'h8000, 16'h7fff, 16'h0001, 16'h0000, 16'h0000, OBS_PRESENT,
                      1'b1, 1'b1));
    send_dim(make_dim(16'h7fff, 16'h7fff, 16'hffff, 16'h0000, 16'h0000, OBS_ABSENT,
                      1'b1, 1'b0));
    send_dim(make_dim(16'h8000, 16'h7fff, 16'h0000, 16'h4000, 16'hc000, OBS_PRESENT,
                      1'b1, 1'b1));
    // pause the sender until all results are back
    wait_drained();

    phase_bias[0] = 16'h7fff;
    phase_bias[1] = 16'h8000;
    phase_bias[2] = IN_W'($urandom);
    phase_bias[3] = 16'h0001;
    phase_bias[4] = 16'hffff;
    phase_bias[5] = narrow_signed(15);

    for (phase = 0; phase < NUM_PHASES; phase++) begin
      write_bias(phase_bias[phase]);
      // one phase runs with no idling at all, others now and then
      calm = (phase == 2) || ($urandom_range(0, 4) == 0);
      sent = 0;
      while (sent < WORDS_PER_PHASE) begin
        ndim = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 8) : $urandom_range(1, 4);
        for (k = 0; k < ndim; k++) begin
          dw = random_dim(k == ndim - 1);
          send_dim(dw);
          sent++;
        end
        if (phase != 2 && $urandom_range(0, 9) == 0) calm = ~calm;
        if ($urandom_range(0, 39) == 0) wait_drained();
      end
      wait_drained();
    end

    calm = 1'b0;
    repeat (20) @(posedge clk_i);
    if (mismatches == 0 && pending_pairs == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin : watchdog
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
